>>> hw/rtl/lpcf_pkg.sv
// Shared types and constants for the length-prefixed chunk framer.
// No dependencies; imported by every module of the block.
package lpcf_pkg;

    // request codes carried in the input tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    localparam int BYTE_W        = 8;
    localparam int REQ_W         = 2;
    localparam int FILL_W        = 8;   // fill level and chunk length, 0..255
    localparam int LANES         = 8;   // bytes per output word
    localparam int LANE_W        = 3;
    localparam int OUT_W         = LANES * BYTE_W;
    localparam int CNT_W         = 4;   // 1..8 valid lanes
    localparam int TOT_W         = 9;   // bytes of one emission, up to 257
    localparam int WIDX_W        = 6;   // word index, up to 32
    localparam int QDEPTH        = 4;
    localparam int CHUNK_MAX_DEF = 255;

    // one command from front to back: optional emission, then optional store
    typedef struct packed {
        logic [FILL_W-1:0] emit_len;   // buffered bytes to send, 0 for none
        logic              term;       // append zero terminator byte
        logic              store_en;   // store a data byte afterwards
        logic [FILL_W-1:0] store_idx;
        logic [BYTE_W-1:0] store_byte;
    } t_cmd;

endpackage

>>> hw/rtl/lpcf_fifo.sv
// Small command queue between the framer front and back.
// Depends on lpcf_pkg for the command type and queue depth.
module lpcf_fifo
    import lpcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd               r_buf [QDEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rptr];

    // pointer and occupancy update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/lpcf_front.sv
// Framer front: accepts requests, tracks the fill level, issues commands.
// Depends on lpcf_pkg for request codes and the command type.
module lpcf_front
    import lpcf_pkg::*;
#(
    parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // data_byte
    input  logic [REQ_W-1:0]  i_s_tuser,   // req_type
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam logic [FILL_W-1:0] LP_CMAX = FILL_W'(CHUNK_MAX);

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              acc;
    logic              need;

    assign o_s_tready = !i_q_full;
    assign acc        = i_s_tvalid && !i_q_full;

    // classify the request into an emission and/or a store
    always_comb begin
        o_cmd            = '0;
        o_cmd.store_byte = i_s_tdata;
        n_fill           = r_fill;
        need             = 1'b0;
        case (i_s_tuser)
            REQ_WRITE: begin
                need           = 1'b1;
                o_cmd.store_en = 1'b1;
                if (r_fill >= LP_CMAX) begin
                    o_cmd.emit_len  = r_fill;
                    o_cmd.store_idx = '0;
                    n_fill          = FILL_W'(1);
                end else begin
                    o_cmd.store_idx = r_fill;
                    n_fill          = r_fill + 1'b1;
                end
            end
            REQ_FLUSH: begin
                need           = (r_fill != '0);
                o_cmd.emit_len = r_fill;
                n_fill         = '0;
            end
            REQ_CLOSE: begin
                need           = 1'b1;
                o_cmd.emit_len = r_fill;
                o_cmd.term     = 1'b1;
                n_fill         = '0;
            end
            default: begin
                // unused code: no effect
                need = 1'b0;
            end
        endcase
    end

    assign o_push = acc && need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (acc) begin
            r_fill <= n_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LP_CMAX)
        else $error("fill level above chunk limit");

endmodule

>>> hw/rtl/lpcf_back.sv
// Framer back: holds the chunk store and streams out packed chunk words.
// Depends on lpcf_pkg for the command type and word geometry.
module lpcf_back
    import lpcf_pkg::*;
#(
    parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_cmd             i_q_cmd,
    output logic             o_q_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // out_bytes
    output logic [CNT_W-1:0] o_m_tuser,   // out_count
    output logic             o_m_tlast    // last_word
);

    localparam int ROWS  = (CHUNK_MAX + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // chunk store, one row holds eight bytes
    logic [OUT_W-1:0]  r_mem [ROWS];
    logic [OUT_W-1:0]  r_row;
    logic [BYTE_W-1:0] r_prev7;

    // emission sequencer
    logic              r_busy;
    logic [FILL_W-1:0] r_len;
    logic [TOT_W-1:0]  r_tot;
    logic [WIDX_W-1:0] r_w;
    logic              r_store_pend;
    logic [FILL_W-1:0] r_sidx;
    logic [BYTE_W-1:0] r_sbyte;

    // read stage
    logic              r_rd_valid;
    logic [WIDX_W-1:0] r_rd_w;
    logic [FILL_W-1:0] r_rd_len;
    logic [CNT_W-1:0]  r_rd_cnt;
    logic              r_rd_last;

    // output register
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic              pop_emit;
    logic              fire_b;
    logic              issue;
    logic [TOT_W-1:0]  rem;
    logic              iss_last;
    logic [CNT_W-1:0]  iss_cnt;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [FILL_W-1:0] wr_idx;
    logic [BYTE_W-1:0] wr_byte;
    logic [TOT_W-1:0]  new_tot;
    logic [OUT_W-1:0]  n_word;

    assign o_q_pop  = !r_busy && i_q_valid;
    assign pop_emit = (i_q_cmd.emit_len != '0) || i_q_cmd.term;
    assign fire_b   = r_rd_valid && (!r_out_valid || i_m_tready);
    assign issue    = r_busy && (!r_rd_valid || fire_b);

    // word accounting for the word being issued
    assign rem      = r_tot - {r_w, 3'b000};
    assign iss_last = (rem <= TOT_W'(LANES));
    assign iss_cnt  = iss_last ? rem[CNT_W-1:0] : CNT_W'(LANES);
    assign rd_row   = (r_w < WIDX_W'(ROWS)) ? r_w[ROW_W-1:0] : '0;

    always_comb begin
        new_tot = '0;
        if (i_q_cmd.emit_len != '0) begin
            new_tot = {1'b0, i_q_cmd.emit_len} + 1'b1;
        end
        new_tot = new_tot + {{(TOT_W-1){1'b0}}, i_q_cmd.term};
    end

    // store write: right away, or after the last read of a pending emission
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = i_q_cmd.store_idx;
        wr_byte = i_q_cmd.store_byte;
        if (o_q_pop && !pop_emit && i_q_cmd.store_en) begin
            wr_en = 1'b1;
        end else if (issue && iss_last && r_store_pend) begin
            wr_en   = 1'b1;
            wr_idx  = r_sidx;
            wr_byte = r_sbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx[ROW_W+2:3]][wr_idx[LANE_W-1:0]*BYTE_W +: BYTE_W] <= wr_byte;
        end
        if (issue) begin
            r_row <= r_mem[rd_row];
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_store_pend <= 1'b0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (o_q_pop && pop_emit) begin
                r_busy       <= 1'b1;
                r_store_pend <= i_q_cmd.store_en;
            end else if (issue && iss_last) begin
                r_busy       <= 1'b0;
                r_store_pend <= 1'b0;
            end
            if (issue) begin
                r_rd_valid <= 1'b1;
            end else if (fire_b) begin
                r_rd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && pop_emit) begin
            r_len   <= i_q_cmd.emit_len;
            r_tot   <= new_tot;
            r_w     <= '0;
            r_sidx  <= i_q_cmd.store_idx;
            r_sbyte <= i_q_cmd.store_byte;
        end else if (issue) begin
            r_w <= r_w + 1'b1;
        end
        if (issue) begin
            r_rd_w    <= r_w;
            r_rd_len  <= r_len;
            r_rd_cnt  <= iss_cnt;
            r_rd_last <= iss_last;
        end
        if (fire_b) begin
            r_prev7 <= r_row[OUT_W-1 -: BYTE_W];
        end
    end

    // lane assembly: length byte, payload, then zeros (terminator included)
    always_comb begin
        logic [TOT_W-1:0] j;
        logic [TOT_W-1:0] len9;
        n_word = '0;
        len9   = {1'b0, r_rd_len};
        for (int k = 0; k < LANES; k++) begin
            j = {r_rd_w, 3'b000} + TOT_W'(k);
            if ((r_rd_len != '0) && (j == '0)) begin
                n_word[k*BYTE_W +: BYTE_W] = r_rd_len;
            end else if ((j != '0) && (j <= len9)) begin
                if (k == 0) begin
                    n_word[k*BYTE_W +: BYTE_W] = r_prev7;
                end else begin
                    n_word[k*BYTE_W +: BYTE_W] = r_row[(k-1)*BYTE_W +: BYTE_W];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_b) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_b) begin
            r_out_data <= n_word;
            r_out_cnt  <= r_rd_cnt;
            r_out_last <= r_rd_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_cnt;
    assign o_m_tlast  = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser != '0) && (o_m_tuser <= CNT_W'(LANES)))
        else $error("output byte count out of range");

    a_wr_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_busy) |-> (issue && iss_last))
        else $error("store written while a chunk is still being read");

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !fire_b) |=> r_rd_valid)
        else $error("read stage dropped a word");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !r_busy && !r_store_pend)
        else $error("command taken while emission in progress");

endmodule

>>> hw/rtl/length_prefixed_chunk_framer.sv
// Length-prefixed chunk framer. Write requests are accepted one per cycle while the
// command queue has room. With the back idle, an emitting request passes the queue, the
// sequencer, the read stage and the output register, and then one word per cycle follows
// while the receiver is ready (ceil(bytes/8) words, at most 33), paced by the single row
// read port of the chunk store. Synchronous active-low reset clears the fill level, the
// queue and all valid flags; the chunk store is not cleared and needs no clearing pass.
module length_prefixed_chunk_framer
    import lpcf_pkg::*;
#(
    parameter int CHUNK_MAX = CHUNK_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,  // data_byte
    input  logic [REQ_W-1:0] i_s_tuser,   // req_type
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // out_bytes
    output logic [CNT_W-1:0] o_m_tuser,   // out_count
    output logic             o_m_tlast    // last_word
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_pop;
    logic q_valid;
    t_cmd q_out;

    // request classification and fill tracking
    lpcf_front #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    // command queue
    lpcf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    // chunk store and word emission
    lpcf_back #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

>>> tb/length_prefixed_chunk_framer_test.sv
// Self-checking testbench for the length-prefixed chunk framer.
// Predicts every emitted word from accepted requests; depends on lpcf_pkg and the framer RTL.
module length_prefixed_chunk_framer_test;
    import lpcf_pkg::*;

    localparam int CHUNK_LIMIT = CHUNK_MAX_DEF;
    // code 3 has no meaning; the framer must drop it
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [OUT_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_framed_word;

    // Tracks the chunk buffer and holds the words each request should produce
    class chunk_frame_predictor;
        logic [BYTE_W-1:0] chunk_bytes [CHUNK_LIMIT];
        int                fill_level;
        logic [BYTE_W-1:0] stream_bytes [$];
        t_framed_word      pending_words [$];
        int                failures;

        function new();
            fill_level = 0;
            failures   = 0;
        endfunction

        // length byte then the buffered payload; nothing for an empty buffer
        function void send_buffered_chunk();
            if (fill_level == 0) return;
            stream_bytes.push_back(BYTE_W'(fill_level));
            for (int i = 0; i < fill_level; i++) stream_bytes.push_back(chunk_bytes[i]);
            fill_level = 0;
        endfunction

        function void accept_request(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] data);
            int           total;
            int           lanes;
            t_framed_word word;
            stream_bytes.delete();
            case (req)
                REQ_WRITE: begin
                    if (fill_level >= CHUNK_LIMIT) send_buffered_chunk();
                    chunk_bytes[fill_level] = data;
                    fill_level++;
                end
                REQ_FLUSH: send_buffered_chunk();
                REQ_CLOSE: begin
                    send_buffered_chunk();
                    stream_bytes.push_back(8'h00);
                end
                default: ;
            endcase
            // pack eight bytes per word, earliest in the low lane
            total = stream_bytes.size();
            for (int w = 0; w * LANES < total; w++) begin
                lanes = total - w * LANES;
                if (lanes > LANES) lanes = LANES;
                word = '0;
                for (int k = 0; k < lanes; k++)
                    word.bytes[k*BYTE_W +: BYTE_W] = stream_bytes[w*LANES + k];
                word.count = CNT_W'(lanes);
                word.last  = ((w + 1) * LANES >= total);
                pending_words.push_back(word);
            end
        endfunction

        function void check_word(logic [OUT_W-1:0] bytes, logic [CNT_W-1:0] count,
                                 logic last);
            t_framed_word exp_word;
            if (pending_words.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected word: data=%h count=%0d last=%0b", bytes, count, last);
                return;
            end
            exp_word = pending_words.pop_front();
            if (exp_word.bytes !== bytes || exp_word.count !== count || exp_word.last !== last)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"word mismatch: expected data=%h count=%0d last=%0b, ",
                              "got data=%h count=%0d last=%0b"},
                             exp_word.bytes, exp_word.count, exp_word.last,
                             bytes, count, last);
            end
        endfunction
    endclass

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic [BYTE_W-1:0] i_s_tdata = '0;   // data_byte
    logic [REQ_W-1:0] i_s_tuser  = '0;   // req_type
    logic             i_m_tready = 1'b0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;         // out_bytes
    logic [CNT_W-1:0] o_m_tuser;         // out_count
    logic             o_m_tlast;         // last_word

    int idle_pct  = 0;
    int stall_pct = 0;
    chunk_frame_predictor framer_model = new();

    length_prefixed_chunk_framer #(
        .CHUNK_MAX(CHUNK_LIMIT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // observe both sides of each transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            framer_model.accept_request(i_s_tuser, i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            framer_model.check_word(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // one request, with random idle cycles ahead of it
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_writes(input int n);
        for (int i = 0; i < n; i++) send_request(REQ_WRITE, BYTE_W'($urandom));
    endtask

    // mostly write bursts, most closed by a flush or close, some loose noise
    task automatic random_traffic(input int n_items);
        int sent;
        int burst;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                burst = $urandom_range(20, 1);
                send_writes(burst);
                sent += burst;
                pick = $urandom_range(2);
                if (pick == 0) send_request(REQ_FLUSH, BYTE_W'($urandom));
                else if (pick == 1) send_request(REQ_CLOSE, BYTE_W'($urandom));
                if (pick != 2) sent++;
            end else begin
                pick = $urandom_range(3);
                send_request(REQ_W'(pick), BYTE_W'($urandom));
                if (REQ_W'(pick) != REQ_IGNORED) sent++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty buffer, extremes, ignored code, word boundary
        send_request(REQ_CLOSE, 8'hff);
        send_request(REQ_FLUSH, 8'hff);
        send_request(REQ_IGNORED, 8'hff);
        send_request(REQ_WRITE, 8'h00);
        send_request(REQ_WRITE, 8'hff);
        send_request(REQ_FLUSH, 8'h00);
        send_request(REQ_WRITE, 8'ha5);
        send_request(REQ_CLOSE, 8'h00);
        for (int i = 0; i < 9; i++) send_request(REQ_WRITE, BYTE_W'(8'h11 * i));
        send_request(REQ_FLUSH, 8'h5a);
        send_request(REQ_WRITE, 8'h80);
        send_request(REQ_IGNORED, 8'h00);
        send_request(REQ_WRITE, 8'h01);
        send_request(REQ_CLOSE, 8'h7f);

        // phases of sender idling and receiver stalls
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            random_traffic(32);
        end

        i_s_tvalid <= 1'b0;
        while (framer_model.pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (framer_model.failures == 0 && framer_model.pending_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
